[hw/rtl/ngsf_pkg.sv]
`default_nettype none
package ngsf_pkg;

   localparam int unsigned MAX_ELEMENTS_DEF = 64;
   localparam int unsigned VALUE_WIDTH_DEF  = 32;
   localparam int unsigned OUT_WIDTH        = 32;
   localparam int unsigned CSR_INDEX_WIDTH  = 1;
   localparam int unsigned CSR_DATA_WIDTH   = 1;

   localparam logic [OUT_WIDTH-1:0] NONE_VALUE = '1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SEARCH_RIGHT = 1'b0,
      CSR_WANT_SMALLER = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN,
      ST_DRAIN_START,
      ST_DRAIN
   } state_type;

endpackage
`default_nettype wire

[hw/rtl/ngsf_if.sv]
`default_nettype none
interface ngsf_req_if #(
   parameter int unsigned VALUE_WIDTH = ngsf_pkg::VALUE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] element_value;
   logic                          final_element;

   modport source (output valid, output element_value, output final_element, input ready);
   modport sink   (input valid, input element_value, input final_element, output ready);
endinterface

interface ngsf_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ngsf_pkg::OUT_WIDTH-1:0]  neighbour_value;
   logic                                   neighbour_found;
   logic                                   overflow_seen;
   logic                                   final_result;

   modport source (output valid, output neighbour_value, output neighbour_found,
                   output overflow_seen, output final_result, input ready);
   modport sink   (input valid, input neighbour_value, input neighbour_found,
                   input overflow_seen, input final_result, output ready);
endinterface
`default_nettype wire

[hw/rtl/ngsf_ram.sv]
`default_nettype none
module ngsf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_en,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output      logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      // read data holds until the next read
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

[hw/rtl/ngsf_cmp_unit.sv]
`default_nettype none
module ngsf_cmp_unit #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic signed [VALUE_WIDTH-1:0] top_value,
   input  wire logic signed [VALUE_WIDTH-1:0] cur_value,
   input  wire logic                          want_smaller,
   output      logic                          drop
);

   // pop the top while it does not qualify as neighbour of the current element
   always_comb begin
      if (want_smaller) begin
         drop = (top_value >= cur_value);
      end else begin
         drop = (top_value <= cur_value);
      end
   end

endmodule
`default_nettype wire

[hw/rtl/nearest_greater_smaller_finder_core.sv]
// load: elements are stored until the final beat; then a start state fetches the first element
//   and the scan state records and pushes each element or pops the stack, at most n-1 pops
// drain: a start state, then one result beat per cycle while rsp_chan.ready is high
// arrays: a new one loads only after the last is drained; scans use the single compare unit
// reset: synchronous, active high; clears state, counts, overflow flag, config and
//   output valid; element, stack and answer memories are not cleared
`default_nettype none
module nearest_greater_smaller_finder_core #(
   parameter int unsigned MAX_ELEMENTS = ngsf_pkg::MAX_ELEMENTS_DEF,
   parameter int unsigned VALUE_WIDTH  = ngsf_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   ngsf_req_if.sink                                     req_chan,
   ngsf_rsp_if.source                                   rsp_chan,
   input  wire logic                                    csr_write_en,
   input  wire logic [ngsf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [ngsf_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import ngsf_pkg::*;

   localparam int unsigned AW = $clog2(MAX_ELEMENTS);
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned AnsW = OUT_WIDTH + 1;

   // configuration
   logic search_right_ff;
   logic want_smaller_ff;

   // sequencer state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;      // stored elements
   logic [CW-1:0] k_ff, k_in;              // scan step / drain index
   logic [CW-1:0] depth_ff, depth_in;      // stack depth incl. cached top
   logic          overflow_ff, overflow_in;
   logic          top_ram_ff, top_ram_in;  // top currently comes from stack read data
   logic signed [VALUE_WIDTH-1:0] top_ff, top_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic                 rsp_final_ff, rsp_final_in;

   // memory ports
   logic                          elem_we, elem_re;
   logic [AW-1:0]                 elem_waddr, elem_raddr;
   logic signed [VALUE_WIDTH-1:0] elem_rdata;
   logic                          stk_we, stk_re;
   logic [AW-1:0]                 stk_waddr, stk_raddr;
   logic signed [VALUE_WIDTH-1:0] stk_rdata;
   logic                          ans_we, ans_re;
   logic [AW-1:0]                 ans_waddr, ans_raddr;
   logic [AnsW-1:0]               ans_wdata, ans_rdata;

   // scan helpers
   logic [CW-1:0] last_idx;
   logic [CW-1:0] scan_idx;
   logic [CW-1:0] next_idx;
   logic signed [VALUE_WIDTH-1:0] top_value;
   logic          drop;
   logic          stack_nz;
   logic          rsp_slot_free;

   assign last_idx  = count_ff - CW'(1);
   assign scan_idx  = search_right_ff ? (last_idx - k_ff) : k_ff;
   assign next_idx  = search_right_ff ? (last_idx - k_ff - CW'(1)) : (k_ff + CW'(1));
   assign top_value = top_ram_ff ? stk_rdata : top_ff;
   assign stack_nz  = (depth_ff != '0);
   assign rsp_slot_free = !rsp_valid_ff || rsp_chan.ready;

   ngsf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock      (clock),
      .write_en   (elem_we),
      .write_addr (elem_waddr),
      .write_data (req_chan.element_value),
      .read_en    (elem_re),
      .read_addr  (elem_raddr),
      .read_data  (elem_rdata)
   );

   // stack entries below the cached top live here
   ngsf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_stack_ram (
      .clock      (clock),
      .write_en   (stk_we),
      .write_addr (stk_waddr),
      .write_data (top_value),
      .read_en    (stk_re),
      .read_addr  (stk_raddr),
      .read_data  (stk_rdata)
   );

   // answer entry: found bit over the output value
   ngsf_ram #(.WIDTH(AnsW), .DEPTH(MAX_ELEMENTS)) u_ans_ram (
      .clock      (clock),
      .write_en   (ans_we),
      .write_addr (ans_waddr),
      .write_data (ans_wdata),
      .read_en    (ans_re),
      .read_addr  (ans_raddr),
      .read_data  (ans_rdata)
   );

   // the one compare unit, used once per scan cycle
   ngsf_cmp_unit #(.VALUE_WIDTH(VALUE_WIDTH)) u_cmp (
      .top_value    (top_value),
      .cur_value    (elem_rdata),
      .want_smaller (want_smaller_ff),
      .drop         (drop)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         search_right_ff <= 1'b0;
         want_smaller_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEARCH_RIGHT: search_right_ff <= csr_write_data[0];
            CSR_WANT_SMALLER: want_smaller_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         k_ff         <= '0;
         depth_ff     <= '0;
         overflow_ff  <= 1'b0;
         top_ram_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         depth_ff     <= depth_in;
         overflow_ff  <= overflow_in;
         top_ram_ff   <= top_ram_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_final_ff <= rsp_final_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      depth_in     = depth_ff;
      overflow_in  = overflow_ff;
      top_ram_in   = top_ram_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_final_in = rsp_final_ff;

      elem_we    = 1'b0;
      elem_waddr = count_ff[AW-1:0];
      elem_re    = 1'b0;
      elem_raddr = scan_idx[AW-1:0];
      stk_we     = 1'b0;
      stk_waddr  = AW'(depth_ff - CW'(1));
      stk_re     = 1'b0;
      stk_raddr  = AW'(depth_ff - CW'(2));
      ans_we     = 1'b0;
      ans_waddr  = scan_idx[AW-1:0];
      ans_wdata  = stack_nz ? {1'b1, OUT_WIDTH'(top_value)} : {1'b0, NONE_VALUE};
      ans_re     = 1'b0;
      ans_raddr  = k_ff[AW-1:0];

      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               // full store: element dropped, final beat still starts the scan
               if (count_ff < CW'(MAX_ELEMENTS)) begin
                  elem_we  = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_chan.final_element) begin
                  state_in = ST_START;
               end
            end
         end

         ST_START: begin
            // fetch the first element of the scan order
            elem_re    = 1'b1;
            k_in       = '0;
            depth_in   = '0;
            top_ram_in = 1'b0;
            state_in   = ST_SCAN;
         end

         ST_SCAN: begin
            if (stack_nz && drop) begin
               // pop; next entry down comes back as stack read data
               depth_in = depth_ff - CW'(1);
               if (depth_ff > CW'(1)) begin
                  stk_re     = 1'b1;
                  top_ram_in = 1'b1;
               end
            end else begin
               // record answer, push current element as new cached top
               ans_we     = 1'b1;
               stk_we     = stack_nz;
               top_in     = elem_rdata;
               top_ram_in = 1'b0;
               depth_in   = depth_ff + CW'(1);
               k_in       = k_ff + CW'(1);
               if (k_ff == last_idx) begin
                  state_in = ST_DRAIN_START;
               end else begin
                  elem_re    = 1'b1;
                  elem_raddr = next_idx[AW-1:0];
               end
            end
         end

         ST_DRAIN_START: begin
            ans_re    = 1'b1;
            ans_raddr = '0;
            k_in      = '0;
            state_in  = ST_DRAIN;
         end

         ST_DRAIN: begin
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = ans_rdata[OUT_WIDTH-1:0];
               rsp_found_in = ans_rdata[OUT_WIDTH];
               rsp_ovf_in   = overflow_ff;
               rsp_final_in = (k_ff == last_idx);
               if (k_ff == last_idx) begin
                  // array done, back to loading with the scan index at zero
                  count_in    = '0;
                  depth_in    = '0;
                  k_in        = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  ans_re    = 1'b1;
                  ans_raddr = AW'(k_ff + CW'(1));
                  k_in      = k_ff + CW'(1);
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.neighbour_value = rsp_value_ff;
   assign rsp_chan.neighbour_found = rsp_found_ff;
   assign rsp_chan.overflow_seen   = rsp_ovf_ff;
   assign rsp_chan.final_result    = rsp_final_ff;

`ifndef SYNTHESIS
   // the stack never holds more entries than the scan has visited
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (depth_ff <= k_ff))
      else $error("stack depth beyond scanned elements");

   // element count stays within capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("element count beyond capacity");

   // a new result beat is only produced while draining
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_chan.ready)) |-> (state_ff == ST_DRAIN))
      else $error("result beat outside drain");

   // a scan never starts on an empty array
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |-> (count_ff != '0))
      else $error("scan started with no elements");

   // after the final result the block is loading with cleared counts
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && rsp_slot_free && k_ff == last_idx)
      |=> (state_ff == ST_LOAD && count_ff == '0 && !overflow_ff))
      else $error("array state not cleared after final result");
`endif

endmodule
`default_nettype wire
